// ===== hdl/c2f_pkg.sv =====
package c2f_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_X,
    ST_SCAN_Y,
    ST_SCAN_CMP,
    ST_ADV_RD,
    ST_ADV_W,
    ST_ADV_P1,
    ST_ADV_P2,
    ST_ADV_P3,
    ST_ADV_P4,
    ST_NXT_RD,
    ST_NXT_LD,
    ST_PRV_LD,
    ST_NORM,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_SUM,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_PRJ_0,
    ST_PRJ_1,
    ST_PRJ_2,
    ST_PRJ_3,
    ST_PRJ_4,
    ST_DONE
  } state_e;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // 100000 m in q8 and its square
  localparam logic [32:0] FAR_Q8 = 33'd25600000;
  localparam logic [51:0] FAR_SQ = 52'd655360000000000;

  localparam int UNIT_FRAC = 28;
  localparam int DIV_STEPS = UNIT_FRAC + 1;

  localparam logic signed [63:0] RND_HALF = 64'sh0000_0000_0800_0000;
  localparam logic signed [63:0] S32_MAX  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN  = -64'sh0000_0000_8000_0000;

  localparam logic [63:0] SQ_BIT_TOP = 64'h4000_0000_0000_0000;

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = -32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

// ===== hdl/cartesian_to_frenet.sv =====
// Projects a Cartesian position onto a closed track of waypoints and returns
// Frenet s and d (signed Q23.8 metres) plus the index of the waypoint ahead.
// A load transaction (tuser = 0) writes one waypoint into the table and
// produces no output. A query transaction (tuser = 1) runs on one shared
// multiplier, one restoring square root and one restoring divider under a
// sequencer and is not ready meanwhile: it runs the nearest-waypoint scan
// over the active waypoints via the table read port, the advance test
// and table reads, a normalizing shift, the squares and the square root,
// the two divisions and the projection and the output load. A zero-length
// segment goes from the table reads straight to the output. A finished
// result waits in the output register while the next transaction is taken.
module cartesian_to_frenet
  import c2f_pkg::*;
#(
  parameter int MAX_WAYPOINTS = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [8:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // waypoint_index, pos_x, pos_y, waypoint_s, dir_x, dir_y, zero pad
  input  logic [135:0] s_axis_tdata,
  // command
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // s coordinate, d coordinate, next_waypoint
  output logic [71:0]  m_axis_tdata
);

  localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int NW = $clog2(MAX_WAYPOINTS + 1);
  localparam int RW = 95;

  state_e state_q, state_d;

  logic [8:0]    cfg_q;
  logic [NW-1:0] n_eff;

  logic                 s_acc;
  logic [7:0]           in_idx;
  logic signed [31:0]   in_px, in_py;
  logic [30:0]          in_s;
  logic signed [15:0]   in_hx, in_hy;
  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [RW-1:0]        ram_rdata;
  logic signed [31:0]   rd_x, rd_y;
  logic [30:0]          rd_s;

  logic signed [31:0] px_q, py_q;
  logic signed [15:0] hx_q, hy_q;
  logic [NW-1:0]      i_q;
  logic [AW-1:0]      pick_q, next_q, prev_c, next_c;
  logic [51:0]        best_q, d2;
  logic               far_q;
  logic signed [32:0] ey_q, wx_q, wy_q, vx_q, vy_q, rx_q, ry_q;
  logic signed [31:0] nx_q, ny_q;
  logic [32:0]        m_q;
  logic [30:0]        ts_q;
  logic signed [63:0] acc_q, dp_q, mul_p, sum_c, dif_c;
  logic [63:0]        sq_n_q, sq_res_q, sq_bit_q, sq_t;
  logic [32:0]        rem_q, rem_sub, div_l;
  logic [28:0]        quo_q, quo_fin;
  logic [4:0]         div_cnt_q;
  logic               div_sel_q, div_ge, div_last, adv, scan_last;
  logic signed [29:0] ux_q, uy_q, u_fin;
  logic signed [31:0] res_s_q, res_d_q;
  logic               m_valid_q, out_load;
  logic [71:0]        m_data_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_q;

  logic signed [32:0] ex_c, ey_c, wx_c, wy_c, vx_c, vy_c;
  logic [32:0]        ax_c, ay_c;
  logic [NW-1:0]      inc_c;

  assign in_idx = s_axis_tdata[7:0];
  assign in_px  = s_axis_tdata[39:8];
  assign in_py  = s_axis_tdata[71:40];
  assign in_s   = s_axis_tdata[102:72];
  assign in_hx  = s_axis_tdata[118:103];
  assign in_hy  = s_axis_tdata[134:119];

  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign ram_we = s_acc && (s_axis_tuser[0] == CMD_LOAD) && (32'(in_idx) < MAX_WAYPOINTS);

  c2f_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_WAYPOINTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(in_idx)),
    .wdata_i({in_s, in_py, in_px}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_x = ram_rdata[31:0];
  assign rd_y = ram_rdata[63:32];
  assign rd_s = ram_rdata[94:64];

  always_comb begin
    if (cfg_q == 9'd0) begin
      n_eff = NW'(1);
    end else if (32'(cfg_q) > MAX_WAYPOINTS) begin
      n_eff = NW'(MAX_WAYPOINTS);
    end else begin
      n_eff = NW'(cfg_q);
    end
  end

  assign mul_p = mul_q[63:0];
  assign sum_c = acc_q + mul_p;
  assign dif_c = acc_q - mul_p;
  assign d2    = acc_q[51:0] + mul_q[51:0];

  assign ex_c = 33'(rd_x) - 33'(px_q);
  assign ey_c = 33'(rd_y) - 33'(py_q);
  assign wx_c = ex_c;
  assign wy_c = ey_c;
  assign vx_c = 33'(nx_q) - 33'(rd_x);
  assign vy_c = 33'(ny_q) - 33'(rd_y);
  assign ax_c = abs33(vx_c);
  assign ay_c = abs33(vy_c);

  assign scan_last = (i_q == NW'(n_eff - NW'(1)));

  assign adv    = abs64(dp_q) < abs64(dif_c);
  assign inc_c  = NW'(pick_q) + NW'(1);
  assign next_c = !adv ? pick_q : ((inc_c >= n_eff) ? '0 : AW'(inc_c));
  assign prev_c = (next_q == '0) ? AW'(n_eff - NW'(1)) : next_q - AW'(1);

  assign sq_t = sq_res_q + sq_bit_q;

  assign div_l    = 33'(sq_res_q[30:0]);
  assign div_ge   = rem_q >= div_l;
  assign rem_sub  = div_ge ? rem_q - div_l : rem_q;
  assign quo_fin  = {quo_q[27:0], div_ge};
  assign div_last = (div_cnt_q == 5'(DIV_STEPS - 1));
  assign u_fin    = (div_sel_q ? vy_q[32] : vx_q[32]) ? -30'(quo_fin) : 30'(quo_fin);

  assign out_load = !m_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc && (s_axis_tuser[0] == CMD_QUERY)) begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD:  state_d = ST_SCAN_X;
      ST_SCAN_X:   state_d = ST_SCAN_Y;
      ST_SCAN_Y:   state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: state_d = scan_last ? ST_ADV_RD : ST_SCAN_RD;
      ST_ADV_RD:   state_d = ST_ADV_W;
      ST_ADV_W:    state_d = ST_ADV_P1;
      ST_ADV_P1:   state_d = ST_ADV_P2;
      ST_ADV_P2:   state_d = ST_ADV_P3;
      ST_ADV_P3:   state_d = ST_ADV_P4;
      ST_ADV_P4:   state_d = ST_NXT_RD;
      ST_NXT_RD:   state_d = ST_NXT_LD;
      ST_NXT_LD:   state_d = ST_PRV_LD;
      ST_PRV_LD:   state_d = ((vx_c == '0) && (vy_c == '0)) ? ST_DONE : ST_NORM;
      ST_NORM: begin
        if ((m_q[32:30] == '0) && (m_q[29] == 1'b1)) begin
          state_d = ST_SQ_X;
        end
      end
      ST_SQ_X:     state_d = ST_SQ_Y;
      ST_SQ_Y:     state_d = ST_SQ_SUM;
      ST_SQ_SUM:   state_d = ST_SQRT;
      ST_SQRT:     state_d = sq_bit_q[0] ? ST_DIV_INIT : ST_SQRT;
      ST_DIV_INIT: state_d = ST_DIV_STEP;
      ST_DIV_STEP: begin
        if (div_last) begin
          state_d = div_sel_q ? ST_PRJ_0 : ST_DIV_INIT;
        end
      end
      ST_PRJ_0:    state_d = ST_PRJ_1;
      ST_PRJ_1:    state_d = ST_PRJ_2;
      ST_PRJ_2:    state_d = ST_PRJ_3;
      ST_PRJ_3:    state_d = ST_PRJ_4;
      ST_PRJ_4:    state_d = ST_DONE;
      ST_DONE:     state_d = out_load ? ST_IDLE : ST_DONE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    ram_raddr     = AW'(i_q);
    mul_a         = 33'(hx_q);
    mul_b         = wx_c;
    unique case (state_q)
      ST_SCAN_X: begin
        mul_a = ex_c;
        mul_b = ex_c;
      end
      ST_SCAN_Y: begin
        mul_a = ey_q;
        mul_b = ey_q;
      end
      ST_ADV_RD: ram_raddr = pick_q;
      ST_ADV_P1: begin
        mul_a = 33'(hy_q);
        mul_b = wy_q;
      end
      ST_ADV_P2: begin
        mul_a = 33'(hx_q);
        mul_b = wy_q;
      end
      ST_ADV_P3: begin
        mul_a = 33'(hy_q);
        mul_b = wx_q;
      end
      ST_NXT_RD: ram_raddr = next_q;
      ST_NXT_LD: ram_raddr = prev_c;
      ST_SQ_X: begin
        mul_a = vx_q;
        mul_b = vx_q;
      end
      ST_SQ_Y: begin
        mul_a = vy_q;
        mul_b = vy_q;
      end
      ST_PRJ_0: begin
        mul_a = rx_q;
        mul_b = 33'(ux_q);
      end
      ST_PRJ_1: begin
        mul_a = ry_q;
        mul_b = 33'(uy_q);
      end
      ST_PRJ_2: begin
        mul_a = rx_q;
        mul_b = 33'(uy_q);
      end
      ST_PRJ_3: begin
        mul_a = ry_q;
        mul_b = 33'(ux_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= 9'd2;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if ((state_q == ST_DONE) && out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    mul_q <= 66'(mul_a) * 66'(mul_b);
    unique case (state_q)
      ST_IDLE: begin
        px_q   <= in_px;
        py_q   <= in_py;
        hx_q   <= in_hx;
        hy_q   <= in_hy;
        i_q    <= '0;
        pick_q <= '0;
        best_q <= FAR_SQ;
      end
      ST_SCAN_X: begin
        ey_q  <= ey_c;
        far_q <= (abs33(ex_c) >= FAR_Q8) || (abs33(ey_c) >= FAR_Q8);
      end
      ST_SCAN_Y: acc_q <= mul_p;
      ST_SCAN_CMP: begin
        if (!far_q && (d2 < best_q)) begin
          best_q <= d2;
          pick_q <= AW'(i_q);
        end
        i_q <= i_q + NW'(1);
      end
      ST_ADV_W: begin
        wx_q <= wx_c;
        wy_q <= wy_c;
      end
      ST_ADV_P1: acc_q <= mul_p;
      ST_ADV_P2: dp_q  <= sum_c;
      ST_ADV_P3: acc_q <= mul_p;
      ST_ADV_P4: next_q <= next_c;
      ST_NXT_LD: begin
        nx_q <= rd_x;
        ny_q <= rd_y;
      end
      ST_PRV_LD: begin
        vx_q    <= vx_c;
        vy_q    <= vy_c;
        rx_q    <= 33'(px_q) - 33'(rd_x);
        ry_q    <= 33'(py_q) - 33'(rd_y);
        ts_q    <= rd_s;
        m_q     <= (ax_c > ay_c) ? ax_c : ay_c;
        res_s_q <= 32'(rd_s);
        res_d_q <= '0;
      end
      ST_NORM: begin
        if (m_q[32:30] != '0) begin
          m_q  <= m_q >> 1;
          vx_q <= vx_q >>> 1;
          vy_q <= vy_q >>> 1;
        end else if (m_q[29] == 1'b0) begin
          m_q  <= m_q << 1;
          vx_q <= vx_q <<< 1;
          vy_q <= vy_q <<< 1;
        end
      end
      ST_SQ_Y: acc_q <= mul_p;
      ST_SQ_SUM: begin
        sq_n_q    <= 64'(sum_c);
        sq_res_q  <= '0;
        sq_bit_q  <= SQ_BIT_TOP;
        div_sel_q <= 1'b0;
      end
      ST_SQRT: begin
        if (sq_n_q >= sq_t) begin
          sq_n_q   <= sq_n_q - sq_t;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      ST_DIV_INIT: begin
        rem_q     <= div_sel_q ? abs33(vy_q) : abs33(vx_q);
        quo_q     <= '0;
        div_cnt_q <= '0;
      end
      ST_DIV_STEP: begin
        rem_q     <= {rem_sub[31:0], 1'b0};
        quo_q     <= quo_fin;
        div_cnt_q <= div_cnt_q + 5'd1;
        if (div_last) begin
          if (div_sel_q) begin
            uy_q <= u_fin;
          end else begin
            ux_q <= u_fin;
          end
          div_sel_q <= 1'b1;
        end
      end
      ST_PRJ_1: acc_q <= mul_p;
      ST_PRJ_2: dp_q  <= sum_c;
      ST_PRJ_3: acc_q <= mul_p;
      ST_PRJ_4: begin
        res_s_q <= sat32($signed(64'(ts_q)) + ((dp_q + RND_HALF) >>> UNIT_FRAC));
        res_d_q <= sat32((dif_c + RND_HALF) >>> UNIT_FRAC);
      end
      ST_DONE: begin
        if (out_load) begin
          m_data_q <= {8'(next_q), res_d_q, res_s_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== hdl/c2f_ram.sv =====
module c2f_ram #(
  parameter int WIDTH = 95,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
